>>> src/lcddfw_pkg.sv
// Shared types and constants for the LCD decimal field writer.
package lcddfw_pkg;

  // Field widths fixed by the bus and the number format
  localparam int VALUE_W  = 16;
  localparam int COUNT_W  = 4;
  localparam int BYTE_W   = 8;
  localparam int NIBBLE_W = 4;

  // Bit-serial divide-by-ten
  localparam logic [NIBBLE_W:0]   DIVISOR   = 5'd10;
  localparam logic [COUNT_W-1:0]  LAST_STEP = 4'(VALUE_W - 1);

  // Hard ceiling on digits per transaction (four nibbles each, 32 nibbles max)
  localparam int RESULT_DIGIT_LIMIT = 8;

  // ASCII zone for decimal digits
  localparam logic [NIBBLE_W-1:0] CHAR_ZONE = 4'h3;

  // Register select codes
  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  // Line select codes
  localparam logic [1:0] LINE_FIRST  = 2'd0;
  localparam logic [1:0] LINE_SECOND = 2'd1;

  // Configuration register indexes
  localparam logic REG_FIRST_BASE  = 1'b0;
  localparam logic REG_SECOND_BASE = 1'b1;

  // Reset values of the line bases
  localparam logic [BYTE_W-1:0] FIRST_BASE_RST  = 8'h80;
  localparam logic [BYTE_W-1:0] SECOND_BASE_RST = 8'hC0;

  // Nibble slots within one digit
  typedef enum logic [1:0] {
    PH_CMD_HI  = 2'd0,
    PH_CMD_LO  = 2'd1,
    PH_CHAR_HI = 2'd2,
    PH_CHAR_LO = 2'd3
  } phase_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEND
  } state_t;

endpackage

>>> src/lcd_decimal_field_writer.sv
// Top level: writes a number in decimal to a character LCD over a 4-bit bus.
// Each digit takes a bit-serial divide-by-ten, then its four nibble transactions;
//   the one-bit-per-cycle divider is shared by all digits, so a new input is
//   accepted only once every digit of the last one is sent; a zero count is
//   accepted without any output.
// Reset (rst, synchronous): sequencer idles, line bases return to 0x80 and 0xC0.
module lcd_decimal_field_writer #(
  parameter int MAX_DIGITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_write_en,
  input  logic                             cfg_index,
  input  logic [lcddfw_pkg::BYTE_W-1:0]    cfg_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lcddfw_pkg::VALUE_W-1:0]   value,
  input  logic [lcddfw_pkg::COUNT_W-1:0]   digit_count,
  input  logic [1:0]                       line_select,
  input  logic [lcddfw_pkg::BYTE_W-1:0]    start_column,
  // output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lcddfw_pkg::NIBBLE_W-1:0]  nibble,
  output logic                             reg_select,
  output logic                             last
);
  import lcddfw_pkg::*;

  localparam int DIGIT_LIMIT_I =
    (MAX_DIGITS < RESULT_DIGIT_LIMIT) ? MAX_DIGITS : RESULT_DIGIT_LIMIT;
  localparam logic [COUNT_W-1:0] DIGIT_LIMIT = COUNT_W'(DIGIT_LIMIT_I);

  state_t state, state_next;

  logic [BYTE_W-1:0]   first_line_base;
  logic [BYTE_W-1:0]   second_line_base;
  logic [VALUE_W-1:0]  remaining_value;
  logic [NIBBLE_W-1:0] remainder;
  logic [COUNT_W-1:0]  bit_count;
  logic [COUNT_W-1:0]  digits_left;
  phase_t              nibble_phase;
  logic [BYTE_W-1:0]   column;
  logic [1:0]          line;

  logic                in_fire;
  logic                out_fire;
  logic [COUNT_W-1:0]  count_sat;
  logic [NIBBLE_W:0]   trial;
  logic                trial_ge;
  logic [BYTE_W-1:0]   cmd_byte;
  logic                last_digit;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign count_sat = (digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : digit_count;

  // one restoring step of the divide-by-ten
  assign trial    = {remainder, remaining_value[VALUE_W-1]};
  assign trial_ge = (trial >= DIVISOR);

  assign last_digit = (digits_left == COUNT_W'(1));

  // set-cursor command byte for the current column
  always_comb begin
    case (line)
      LINE_FIRST:  cmd_byte = first_line_base + column;
      LINE_SECOND: cmd_byte = second_line_base + column;
      default:     cmd_byte = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_line_base  <= FIRST_BASE_RST;
      second_line_base <= SECOND_BASE_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FIRST_BASE:  first_line_base  <= cfg_data;
        REG_SECOND_BASE: second_line_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && (count_sat != '0)) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (bit_count == LAST_STEP) state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_fire && (nibble_phase == PH_CHAR_LO)) begin
          state_next = last_digit ? ST_IDLE : ST_DIV;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // outputs
  always_comb begin
    in_ready   = (state == ST_IDLE);
    out_valid  = (state == ST_SEND);
    nibble     = cmd_byte[BYTE_W-1:NIBBLE_W];
    reg_select = RS_COMMAND;
    last       = 1'b0;
    case (nibble_phase)
      PH_CMD_HI: begin
        nibble     = cmd_byte[BYTE_W-1:NIBBLE_W];
        reg_select = RS_COMMAND;
      end
      PH_CMD_LO: begin
        nibble     = cmd_byte[NIBBLE_W-1:0];
        reg_select = RS_COMMAND;
      end
      PH_CHAR_HI: begin
        nibble     = CHAR_ZONE;
        reg_select = RS_DATA;
      end
      PH_CHAR_LO: begin
        nibble     = remainder;
        reg_select = RS_DATA;
        last       = last_digit;
      end
      default: ;
    endcase
  end

  // sequencer control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      digits_left  <= '0;
      nibble_phase <= PH_CMD_HI;
      bit_count    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            digits_left  <= count_sat;
            bit_count    <= '0;
            nibble_phase <= PH_CMD_HI;
          end
        end
        ST_DIV: begin
          bit_count <= bit_count + COUNT_W'(1);
        end
        ST_SEND: begin
          if (out_fire) begin
            nibble_phase <= phase_t'(nibble_phase + 2'd1);
            if (nibble_phase == PH_CHAR_LO) begin
              digits_left <= digits_left - COUNT_W'(1);
              bit_count   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath: value shift register, remainder, column
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          remaining_value <= value;
          remainder       <= '0;
          line            <= line_select;
          column          <= start_column + BYTE_W'(count_sat) - BYTE_W'(1);
        end
      end
      ST_DIV: begin
        remaining_value <= {remaining_value[VALUE_W-2:0], trial_ge};
        remainder       <= trial_ge ? NIBBLE_W'(trial - DIVISOR) : trial[NIBBLE_W-1:0];
      end
      ST_SEND: begin
        if (out_fire && (nibble_phase == PH_CHAR_LO)) begin
          remainder <= '0;
          column    <= column - BYTE_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

>>> dv/tb_lcd_decimal_field_writer.sv
// Testbench for lcd_decimal_field_writer: directed table plus random transactions.
module tb_lcd_decimal_field_writer;
  import lcddfw_pkg::*;

  localparam int DIGIT_CAP   = 8;     // MAX_DIGITS of the instance
  localparam int QUIET_LIMIT = 3000;  // cycles with no transaction before giving up
  localparam int SETTLE      = 40;    // idle cycles before a register write
  localparam int HOLD_OFF    = 300;   // long receiver stall, in cycles

  // One field-write request as it enters the block
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic [1:0]         line;
    logic [BYTE_W-1:0]  column;
  } field_req_t;

  // One nibble transfer on the LCD bus
  typedef struct packed {
    logic [NIBBLE_W-1:0] nib;
    logic                rs;
    logic                fin;
  } bus_nibble_t;

  // Directed row: when known is set, first_digit holds cmd byte and char byte
  typedef struct {
    field_req_t  req;
    bit          known;
    logic [15:0] first_digit;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_write_en;
  logic                cfg_index;
  logic [BYTE_W-1:0]   cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [VALUE_W-1:0]  value;
  logic [COUNT_W-1:0]  digit_count;
  logic [1:0]          line_select;
  logic [BYTE_W-1:0]   start_column;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [NIBBLE_W-1:0] nibble;
  logic                reg_select;
  logic                last;

  // Predictor state and scoreboard
  logic [BYTE_W-1:0] line1_base;
  logic [BYTE_W-1:0] line2_base;
  bus_nibble_t       pending_nibbles[$];
  int                mismatches = 0;
  int                send_gap_pct;
  int                take_gap_pct;
  int                stall_asked = 0;
  int                stall_served = 0;
  int                stall_left = 0;
  int                quiet_cycles = 0;

  lcd_decimal_field_writer #(.MAX_DIGITS(DIGIT_CAP)) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .digit_count  (digit_count),
    .line_select  (line_select),
    .start_column (start_column),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .nibble       (nibble),
    .reg_select   (reg_select),
    .last         (last)
  );

  // Directed stimulus: line extremes, unknown lines, column wrap, zero and
  // oversized counts, value extremes
  dir_row_t dir_rows[18] = '{
    '{'{16'd0,     4'd1,  2'd0, 8'h00}, 1'b1, 16'h8030},
    '{'{16'hFFFF,  4'd1,  2'd1, 8'h00}, 1'b1, 16'hC035},
    '{'{16'd9,     4'd1,  2'd2, 8'h07}, 1'b1, 16'h0039},
    '{'{16'd7,     4'd1,  2'd3, 8'hFF}, 1'b1, 16'h0037},
    '{'{16'd1234,  4'd1,  2'd0, 8'h7F}, 1'b1, 16'hFF34},
    '{'{16'd0,     4'd1,  2'd1, 8'h40}, 1'b1, 16'h0030},
    '{'{16'd42,    4'd0,  2'd0, 8'h00}, 1'b1, 16'h0000},
    '{'{16'hFFFF,  4'd0,  2'd3, 8'hFF}, 1'b1, 16'h0000},
    '{'{16'hFFFF,  4'd5,  2'd0, 8'h00}, 1'b0, 16'h0000},
    '{'{16'hFFFF,  4'd8,  2'd1, 8'hFA}, 1'b0, 16'h0000},
    '{'{16'd12345, 4'd15, 2'd0, 8'h03}, 1'b0, 16'h0000},
    '{'{16'hAAAA,  4'd9,  2'd1, 8'hFF}, 1'b0, 16'h0000},
    '{'{16'h5555,  4'd6,  2'd2, 8'h55}, 1'b0, 16'h0000},
    '{'{16'd1,     4'd2,  2'd3, 8'hAA}, 1'b0, 16'h0000},
    '{'{16'hFFFF,  4'd8,  2'd0, 8'hFF}, 1'b0, 16'h0000},
    '{'{16'd0,     4'd8,  2'd1, 8'h00}, 1'b0, 16'h0000},
    '{'{16'd10000, 4'd12, 2'd0, 8'h10}, 1'b0, 16'h0000},
    '{'{16'h8000,  4'd3,  2'd1, 8'h80}, 1'b0, 16'h0000}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Queue the four nibbles of one digit: cursor byte, then character byte
  task automatic queue_digit(input logic [7:0] cmd, input logic [7:0] chr, input logic fin);
    pending_nibbles.push_back('{cmd[7:4], RS_COMMAND, 1'b0});
    pending_nibbles.push_back('{cmd[3:0], RS_COMMAND, 1'b0});
    pending_nibbles.push_back('{chr[7:4], RS_DATA, 1'b0});
    pending_nibbles.push_back('{chr[3:0], RS_DATA, fin});
  endtask

  // Expected bus traffic of one request, least significant digit first
  task automatic predict_digit_writes(input field_req_t r);
    int                 n_dig;
    logic [VALUE_W-1:0] rem;
    logic [BYTE_W-1:0]  col;
    logic [BYTE_W-1:0]  cmd;
    n_dig = (r.count > DIGIT_CAP) ? DIGIT_CAP : int'(r.count);
    rem = r.value;
    for (int k = 1; k <= n_dig; k++) begin
      col = r.column + 8'(n_dig - k);
      case (r.line)
        LINE_FIRST:  cmd = line1_base + col;
        LINE_SECOND: cmd = line2_base + col;
        default:     cmd = '0;
      endcase
      queue_digit(cmd, {CHAR_ZONE, 4'(rem % 16'd10)}, k == n_dig);
      rem = rem / 16'd10;
    end
  endtask

  // Offer one request, hold it until taken, then queue its expected nibbles
  task automatic drive_item(input field_req_t r, input bit known, input logic [15:0] first);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    value        <= r.value;
    digit_count  <= r.count;
    line_select  <= r.line;
    start_column <= r.column;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!known) predict_digit_writes(r);
    else if (r.count != 0) queue_digit(first[15:8], first[7:0], 1'b1);
    @(negedge clk);
  endtask

  // Stop offering, wait for every expected nibble, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_nibbles.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_base(input logic idx, input logic [BYTE_W-1:0] d);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= d;
    case (idx)
      REG_FIRST_BASE:  line1_base = d;
      REG_SECOND_BASE: line2_base = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random_items(input int n);
    field_req_t r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0:       r.value = '0;
        1:       r.value = '1;
        2:       r.value = 16'($urandom_range(99));
        default: r.value = 16'($urandom);
      endcase
      r.count  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                          : 4'($urandom_range(8));
      r.line   = 2'($urandom_range(3));
      r.column = 8'($urandom);
      drive_item(r, 1'b0, '0);
    end
  endtask

  // Receiver: random backpressure, or a long hold-off when asked
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_asked != stall_served) begin
      stall_served <= stall_asked;
      stall_left   <= HOLD_OFF;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // Compare every accepted nibble with the oldest expectation
  always @(posedge clk) begin
    bus_nibble_t exp_n;
    if (!rst && out_valid && out_ready) begin
      if (pending_nibbles.size() == 0) begin
        flag_mismatch($sformatf("unexpected nibble %h rs %b last %b",
                                nibble, reg_select, last));
      end else begin
        exp_n = pending_nibbles.pop_front();
        if (nibble !== exp_n.nib)
          flag_mismatch($sformatf("nibble %h, expected %h", nibble, exp_n.nib));
        if (reg_select !== exp_n.rs)
          flag_mismatch($sformatf("reg_select %b, expected %b", reg_select, exp_n.rs));
        if (last !== exp_n.fin)
          flag_mismatch($sformatf("last %b, expected %b", last, exp_n.fin));
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index    = REG_FIRST_BASE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    value        = '0;
    digit_count  = '0;
    line_select  = '0;
    start_column = '0;
    line1_base   = FIRST_BASE_RST;
    line2_base   = SECOND_BASE_RST;
    send_gap_pct = 21;
    take_gap_pct = 87;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table against reset line bases
    foreach (dir_rows[i])
      drive_item(dir_rows[i].req, dir_rows[i].known, dir_rows[i].first_digit);
    drain();

    // Base extremes, sender mostly busy, receiver mostly stalled
    write_base(REG_FIRST_BASE, 8'h00);
    write_base(REG_SECOND_BASE, 8'hFF);
    send_random_items(30);
    drain();

    // Swapped extremes and swapped idling
    write_base(REG_FIRST_BASE, 8'hFF);
    write_base(REG_SECOND_BASE, 8'h00);
    send_gap_pct = 87;
    take_gap_pct = 21;
    send_random_items(30);
    drain();

    // Random bases, no idling; long receiver hold-off backs up the input
    write_base(REG_FIRST_BASE, 8'($urandom));
    write_base(REG_SECOND_BASE, 8'($urandom));
    send_gap_pct = 0;
    take_gap_pct = 0;
    stall_asked  = stall_asked + 1;
    send_random_items(32);
    drain();

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> lcd_decimal_field_writer.f
src/lcddfw_pkg.sv
src/lcd_decimal_field_writer.sv
dv/tb_lcd_decimal_field_writer.sv
